// File: src/keyed_duration_aggregator_assert.svh
`ifndef KEYED_DURATION_AGGREGATOR_ASSERT_SVH
`define KEYED_DURATION_AGGREGATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define KDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/kda_pkg.sv
package kda_pkg;

	localparam int CAPACITY    = 16;
	localparam int KEY_W       = 32;
	localparam int DEPTH_W     = 8;
	localparam int TIME_W      = 63;
	localparam int SUM_W       = 64;
	localparam int HIT_W       = 32;
	localparam int CNT_W       = 5;
	localparam int LIMIT_RESET = 16;

	typedef struct packed {
		logic [KEY_W-1:0]   name_id;
		logic [DEPTH_W-1:0] nest_depth;
		logic [TIME_W-1:0]  begin_time;
		logic [TIME_W-1:0]  end_time;
		logic               last_sample;
	} sample_t;

	typedef struct packed {
		logic [KEY_W-1:0] entry_name;
		logic [SUM_W-1:0] total_dur;
		logic [HIT_W-1:0] occurrences;
		logic [CNT_W-1:0] entry_count;
		logic             entry_valid;
		logic             last_result;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SUM_W-1:0] sum;
		logic [HIT_W-1:0] hits;
	} entry_t;

	typedef struct packed {
		logic active;
		logic agg;
		logic open;
		logic shift;
	} cell_ctl_t;

	typedef enum logic {
		ST_AGG,
		ST_DRAIN
	} state_t;

endpackage

// File: src/kda_cell.sv
module kda_cell (
	input  logic                           clk,
	input  kda_pkg::cell_ctl_t             ctl,
	input  logic [kda_pkg::KEY_W-1:0]      key,
	input  logic [kda_pkg::SUM_W-1:0]      dur,
	input  kda_pkg::entry_t                nxt,
	output kda_pkg::entry_t                ent,
	output logic                           match
);

	kda_pkg::entry_t ent_q;

	assign ent   = ent_q;
	assign match = ctl.active && (ent_q.key == key);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= nxt;
		end else if (ctl.agg && match) begin
			ent_q.sum  <= ent_q.sum + dur;
			ent_q.hits <= ent_q.hits + kda_pkg::HIT_W'(1);
		end else if (ctl.open) begin
			ent_q.key  <= key;
			ent_q.sum  <= dur;
			ent_q.hits <= kda_pkg::HIT_W'(1);
		end
	end

endmodule

// File: src/keyed_duration_aggregator.sv
// channel   dir  handshake              payload
// sample    in   sample_valid/stall     kda_pkg::sample_t
// result    out  result_valid/stall     kda_pkg::result_t
// cfg       in   cfg_valid/cfg_ready    entry_limit, 5 bits
//
// A sample passes duration prep, then one parallel match across the cell row.
// One sample per cycle until a last sample; the set then drains from cell 0, one
// entry per cycle as the result register frees up; an empty set still gives one result.
// Reset clears control state and the fill count; cell contents are not reset.
// A stalled result holds the drain; sample_stall is high from a last sample to drain end.
module keyed_duration_aggregator #(
	parameter int CAPACITY = kda_pkg::CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  kda_pkg::sample_t              sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output kda_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kda_pkg::CNT_W-1:0]     cfg_data
);

	localparam int CNT_MAX  = (1 << kda_pkg::CNT_W) - 1;
	localparam int CAP_CLIP = (CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY;

	kda_pkg::state_t state_q, state_d;

	logic [kda_pkg::CNT_W-1:0] limit_q, eff_limit;
	logic [kda_pkg::CNT_W-1:0] fill_q, rem_q, tot_q;

	logic                       valid_s1, last_s1, ok_s1;
	logic [kda_pkg::KEY_W-1:0]  key_s1;
	logic [kda_pkg::SUM_W-1:0]  dur_s1;

	logic                       accept, agg_en, hit_any, do_open;
	logic                       out_free, drain_load, drain_done;
	logic                       result_valid_q;
	kda_pkg::result_t           result_q, result_d;

	kda_pkg::entry_t            ents [CAPACITY];
	logic [CAPACITY-1:0]        match_vec;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q == kda_pkg::ST_DRAIN) || (valid_s1 && last_s1);
	assign accept       = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign eff_limit = (limit_q < kda_pkg::CNT_W'(CAP_CLIP)) ? limit_q
		: kda_pkg::CNT_W'(CAP_CLIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= kda_pkg::CNT_W'(kda_pkg::LIMIT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// stage 1: duration and filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1  <= sample.name_id;
			dur_s1  <= {1'b0, sample.end_time - sample.begin_time};
			ok_s1   <= (sample.nest_depth == '0) && (sample.end_time >= sample.begin_time);
			last_s1 <= sample.last_sample;
		end
	end

	// stage 2: cell row
	assign agg_en   = (state_q == kda_pkg::ST_AGG) && valid_s1 && ok_s1;
	assign hit_any  = |match_vec;
	assign do_open  = agg_en && !hit_any && (fill_q < eff_limit);

	assign out_free   = !result_valid_q || !result_stall;
	assign drain_load = (state_q == kda_pkg::ST_DRAIN) && out_free;
	assign drain_done = drain_load && ((tot_q == '0) || (rem_q == kda_pkg::CNT_W'(1)));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kda_pkg::cell_ctl_t ctl;
		kda_pkg::entry_t    nxt;

		assign ctl.active = 32'(fill_q) > i;
		assign ctl.agg    = agg_en;
		assign ctl.open   = do_open && (32'(fill_q) == i);
		assign ctl.shift  = drain_load && (tot_q != '0);

		if (i == CAPACITY - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_link
			assign nxt = ents[i+1];
		end

		kda_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.key   (key_s1),
			.dur   (dur_s1),
			.nxt   (nxt),
			.ent   (ents[i]),
			.match (match_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kda_pkg::ST_AGG;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			kda_pkg::ST_AGG: begin
				if (valid_s1 && last_s1) begin
					state_d = kda_pkg::ST_DRAIN;
				end
			end
			kda_pkg::ST_DRAIN: begin
				if (drain_done) begin
					state_d = kda_pkg::ST_AGG;
				end
			end
			default: state_d = kda_pkg::ST_AGG;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rem_q  <= '0;
			tot_q  <= '0;
		end else if (state_q == kda_pkg::ST_AGG) begin
			if (valid_s1 && last_s1) begin
				rem_q <= fill_q + kda_pkg::CNT_W'(do_open);
				tot_q <= fill_q + kda_pkg::CNT_W'(do_open);
			end
			fill_q <= fill_q + kda_pkg::CNT_W'(do_open);
		end else if (drain_done) begin
			fill_q <= '0;
		end else if (drain_load) begin
			rem_q <= rem_q - kda_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		result_d = '0;
		result_d.last_result = 1'b1;
		if (tot_q != '0) begin
			result_d.entry_name  = ents[0].key;
			result_d.total_dur   = ents[0].sum;
			result_d.occurrences = ents[0].hits;
			result_d.entry_count = tot_q;
			result_d.entry_valid = 1'b1;
			result_d.last_result = (rem_q == kda_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= drain_load;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_load) begin
			result_q <= result_d;
		end
	end

`include "keyed_duration_aggregator_assert.svh"

	`KDA_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_q) <= CAP_CLIP, "fill count past capacity")
	`KDA_ASSERT_NEXT(a_last_drains, state_q == kda_pkg::ST_AGG && valid_s1 && last_s1,
		state_q == kda_pkg::ST_DRAIN, "last sample did not start drain")
	`KDA_ASSERT_NOW(a_empty_result, result_valid_q && !result_q.entry_valid,
		result_q.last_result && result_q.entry_count == '0, "bad empty result")
	`KDA_ASSERT_NEXT(a_drain_clears, drain_done, fill_q == '0, "table not cleared after drain")

endmodule
